>>> src/mcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the multi-client check-in watchdog.
package mcw_pkg;

    localparam int SLOT_W  = 4;
    localparam int SILENCE_W = 31;
    localparam logic [SILENCE_W-1:0] SILENCE_RESET = 31'd300;
    localparam int STALE_MAX = 15;

    typedef enum logic [1:0] {
        FUNC_CHECKIN = 2'd0,
        FUNC_HEALTH  = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] client_id;
        logic [31:0] now_tick;
    } req_word_t;

    typedef struct packed {
        logic              checkin_accepted;
        logic [SLOT_W-1:0] slot_used;
        logic              table_full;
        logic              check_passed;
        logic [3:0]        stale_count;
        logic              fpga_kick;
        logic              interrupt_cleared;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request word, clear scan state and result
        logic step;      // advance slot index
        logic ci_hit;    // write id/tick at current slot, record acceptance
        logic ci_full;   // record table full
        logic hc_issue;  // read tick at current slot into eval pipe
        logic hc_final;  // close out health check
        logic to_evt;    // first-timeout event
        logic out_load;  // move result into output register
    } mcw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       id_zero;
        logic       hit;
        logic       last_idx;
        logic       out_free;
    } mcw_sts_t;

endpackage

>>> src/multi_client_watchdog_checkin_top.sv
`timescale 1ns / 1ps
// Top level of the multi-client check-in watchdog supervisor.
// Accept to output valid: DISPATCH, then a check-in scans slots up to a hit or the
// last slot, a health check scans every slot, drains and closes out, and a timeout
// event or ignored word goes straight to FINISH; FINISH loads the output when free.
// One word at a time: the next is taken in the cycle after the output loads.
// The output register holds a finished word while the next one is accepted.
// Reset (rst_n, async low) empties the client table, clears healthy, sets limit to 300.
module multi_client_watchdog_checkin_top #(
    parameter int NUM_CLIENTS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  mcw_pkg::req_word_t req_word,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mcw_pkg::rsp_word_t rsp_word,
    // max_silence_ticks register
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_data
);
    import mcw_pkg::*;

    mcw_cmd_t cmd;
    mcw_sts_t sts;

    // Controller: one state per phase; scans advance one slot a cycle.
    mcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: id flops (reset to empty), tick RAM (no reset, read data only used for
    // filled slots), wrap-safe elapsed compare, stale counter, output register.
    mcw_dp #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

>>> src/mcw_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mcw_dp.sv
`timescale 1ns / 1ps
// Datapath: client id table, tick memory, stale counter, result and output registers.
module mcw_dp #(
    parameter int NUM_CLIENTS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mcw_pkg::req_word_t req_word,
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_data,
    input  mcw_pkg::mcw_cmd_t  cmd,
    output mcw_pkg::mcw_sts_t  sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mcw_pkg::rsp_word_t rsp_word
);
    import mcw_pkg::*;

    localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int CNT_W = $clog2(NUM_CLIENTS + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_CLIENTS - 1);

    logic [15:0]          ids_reg [NUM_CLIENTS];
    logic [SILENCE_W-1:0] max_silence_reg;
    logic                 healthy_reg;
    req_word_t            req_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     stale_reg;
    logic                 pipe_vld_reg;
    logic                 pipe_filled_reg;
    rsp_word_t            res_reg;
    logic                 rsp_valid_reg;
    rsp_word_t            rsp_word_reg;

    logic [IDX_W-1:0] slot;
    logic [15:0]      slot_id;
    logic [31:0]      last_tick;
    logic [31:0]      elapsed;
    logic             fresh;
    logic             stale_hit;

    assign slot    = idx_reg[IDX_W-1:0];
    assign slot_id = ids_reg[slot];

    mcw_ram #(
        .WIDTH (32),
        .DEPTH (NUM_CLIENTS)
    ) u_tick_ram (
        .clk     (clk),
        .wr_en   (cmd.ci_hit),
        .wr_addr (slot),
        .wr_data (req_reg.now_tick),
        .rd_addr (slot),
        .rd_data (last_tick)
    );

    // negative elapsed time (check-in ahead of now) counts as fresh
    assign elapsed   = req_reg.now_tick - last_tick;
    assign fresh     = elapsed[31] || (elapsed[30:0] < max_silence_reg);
    assign stale_hit = pipe_vld_reg && pipe_filled_reg && !fresh;

    assign sts.func     = req_reg.func;
    assign sts.id_zero  = (req_reg.client_id == 16'd0);
    assign sts.hit      = (slot_id == req_reg.client_id) || (slot_id == 16'd0);
    assign sts.last_idx = (idx_reg == LAST_IDX);
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLIENTS; i++)
            begin
                ids_reg[i] <= 16'd0;
            end
            max_silence_reg <= SILENCE_RESET;
            healthy_reg     <= 1'b0;
            idx_reg         <= '0;
            stale_reg       <= '0;
            pipe_vld_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_silence_reg <= cfg_data;
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.ci_hit)
            begin
                ids_reg[slot] <= req_reg.client_id;
            end

            pipe_vld_reg <= cmd.hc_issue;

            if (cmd.load)
            begin
                stale_reg <= '0;
            end
            else if (stale_hit)
            begin
                stale_reg <= stale_reg + 1'b1;
            end

            if (cmd.hc_final)
            begin
                healthy_reg <= (stale_reg == '0);
            end
            else if (cmd.to_evt)
            begin
                healthy_reg <= 1'b0;
            end

            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_word;
        end
        pipe_filled_reg <= (slot_id != 16'd0);

        if (cmd.load)
        begin
            res_reg <= '0;
        end
        else
        begin
            if (cmd.ci_hit)
            begin
                res_reg.checkin_accepted <= 1'b1;
                res_reg.slot_used        <= SLOT_W'(idx_reg);
            end
            if (cmd.ci_full)
            begin
                res_reg.table_full <= 1'b1;
            end
            if (cmd.hc_final)
            begin
                res_reg.check_passed <= (stale_reg == '0);
                res_reg.fpga_kick    <= (stale_reg == '0);
                res_reg.stale_count  <= (32'(stale_reg) > 32'(STALE_MAX)) ?
                                        4'(STALE_MAX) : 4'(stale_reg);
            end
            if (cmd.to_evt)
            begin
                res_reg.interrupt_cleared <= healthy_reg;
            end
        end

        if (cmd.out_load)
        begin
            rsp_word_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

>>> src/mcw_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences check-in scans, health-check scans and result hand-off.
module mcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output mcw_pkg::mcw_cmd_t cmd,
    input  mcw_pkg::mcw_sts_t sts
);
    import mcw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CI_SCAN,
        ST_HC_SCAN,
        ST_HC_DRAIN,
        ST_HC_FINAL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (func_t'(sts.func))
                    FUNC_CHECKIN:
                    begin
                        state_next = sts.id_zero ? ST_FINISH : ST_CI_SCAN;
                    end
                    FUNC_HEALTH:
                    begin
                        state_next = ST_HC_SCAN;
                    end
                    FUNC_TIMEOUT:
                    begin
                        cmd.to_evt = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_CI_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.ci_hit = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (sts.last_idx)
                begin
                    cmd.ci_full = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_HC_SCAN:
            begin
                cmd.hc_issue = 1'b1;
                if (sts.last_idx)
                begin
                    state_next = ST_HC_DRAIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_HC_DRAIN:
            begin
                state_next = ST_HC_FINAL;
            end
            ST_HC_FINAL:
            begin
                cmd.hc_final = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_ci_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ci_hit && cmd.ci_full))
        else $error("check-in hit and table full in same cycle");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken word");

    a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DISPATCH) && req_stall)
        else $error("accepted word not dispatched");

    a_final_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hc_final |-> $past(state_reg) == ST_HC_DRAIN)
        else $error("health check closed before scan drained");
`endif

endmodule

>>> tb/multi_client_watchdog_checkin_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-client check-in watchdog supervisor.
module multi_client_watchdog_checkin_top_test;

    import mcw_pkg::*;

    localparam int NUM_CLIENTS  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 20;    // longest accept-to-output path is a health check
    localparam int HOLD_CYCLES  = 400;   // receiver hold-off for the back-pressure test
    localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
    localparam int IDLE_PCT     = 13;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      req_valid   = 1'b0;
    logic      req_stall;
    req_word_t req_word    = '0;
    logic      rsp_valid;
    logic      rsp_stall   = 1'b0;
    rsp_word_t rsp_word;
    logic        cfg_wr_en = 1'b0;
    logic [30:0] cfg_data  = '0;

    multi_client_watchdog_checkin_top #(
        .NUM_CLIENTS(NUM_CLIENTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word),
        .cfg_wr_en(cfg_wr_en),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Supervisor model: its own copy of the client table, the healthy flag
    // and the silence limit. Updated in accept order of request words.
    // ------------------------------------------------------------------
    logic [15:0]          roster_id   [NUM_CLIENTS];
    logic [31:0]          roster_tick [NUM_CLIENTS];
    bit                   healthy_q;
    logic [SILENCE_W-1:0] silence_lim;

    rsp_word_t owed_rsp [$];   // result words still to come, oldest first
    rsp_word_t owed_head;
    int        mismatches = 0;

    bit calm      = 1'b0;   // no idling on either side while set
    int hold_trig = 0;      // bumped by a test to start a receiver hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    logic [31:0] tick;      // running system tick used by the sequences

    function automatic rsp_word_t supervise(req_word_t w);
        rsp_word_t   r;
        int unsigned stale;
        logic [31:0] gap;
        bit          done;
        r     = '0;
        stale = 0;
        done  = 1'b0;
        case (func_t'(w.func))
            FUNC_CHECKIN:
            begin
                // id zero is no client at all: nothing happens
                if (w.client_id != 16'd0)
                begin
                    // refresh own slot or claim the first empty one
                    for (int i = 0; i < NUM_CLIENTS; i++)
                    begin
                        if (!done && (roster_id[i] == w.client_id || roster_id[i] == 16'd0))
                        begin
                            roster_id[i]       = w.client_id;
                            roster_tick[i]     = w.now_tick;
                            r.checkin_accepted = 1'b1;
                            r.slot_used        = SLOT_W'(i);
                            done               = 1'b1;
                        end
                    end
                    if (!done)
                        r.table_full = 1'b1;
                end
            end
            FUNC_HEALTH:
            begin
                // scan filled slots; the first empty slot ends the scan
                for (int i = 0; i < NUM_CLIENTS; i++)
                begin
                    if (!done)
                    begin
                        if (roster_id[i] == 16'd0)
                            done = 1'b1;
                        else
                        begin
                            // a check-in in the future (negative gap) counts as fresh
                            gap = w.now_tick - roster_tick[i];
                            if (!gap[31] && gap >= {1'b0, silence_lim})
                                stale++;
                        end
                    end
                end
                if (stale == 0)
                begin
                    healthy_q      = 1'b1;
                    r.check_passed = 1'b1;
                    r.fpga_kick    = 1'b1;
                end
                else
                    healthy_q = 1'b0;
                r.stale_count = (stale > STALE_MAX) ? 4'(STALE_MAX) : 4'(stale);
            end
            FUNC_TIMEOUT:
            begin
                if (healthy_q)
                begin
                    r.interrupt_cleared = 1'b1;
                    healthy_q           = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall at the falling edge, with an optional long
    // hold-off that this process counts down itself.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_trig != hold_seen)
        begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (calm)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Each accepted result word is matched field by field against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp.size() == 0)
                report("result word with nothing owed", int'(rsp_word), 0);
            else
            begin
                owed_head = owed_rsp.pop_front();
                if (rsp_word.checkin_accepted !== owed_head.checkin_accepted)
                    report("checkin_accepted", int'(rsp_word.checkin_accepted),
                           int'(owed_head.checkin_accepted));
                if (rsp_word.slot_used !== owed_head.slot_used)
                    report("slot_used", int'(rsp_word.slot_used),
                           int'(owed_head.slot_used));
                if (rsp_word.table_full !== owed_head.table_full)
                    report("table_full", int'(rsp_word.table_full),
                           int'(owed_head.table_full));
                if (rsp_word.check_passed !== owed_head.check_passed)
                    report("check_passed", int'(rsp_word.check_passed),
                           int'(owed_head.check_passed));
                if (rsp_word.stale_count !== owed_head.stale_count)
                    report("stale_count", int'(rsp_word.stale_count),
                           int'(owed_head.stale_count));
                if (rsp_word.fpga_kick !== owed_head.fpga_kick)
                    report("fpga_kick", int'(rsp_word.fpga_kick),
                           int'(owed_head.fpga_kick));
                if (rsp_word.interrupt_cleared !== owed_head.interrupt_cleared)
                    report("interrupt_cleared", int'(rsp_word.interrupt_cleared),
                           int'(owed_head.interrupt_cleared));
            end
        end
    end

    // Hang detector: any handshake or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. A word is driven at the falling edge and held until a
    // rising edge sees it taken; the model runs at that point.
    // ------------------------------------------------------------------
    task automatic send_word(func_t f, logic [15:0] id, logic [31:0] now);
        req_word_t w;
        bit        taken;
        w.func      = f;
        w.client_id = id;
        w.now_tick  = now;
        taken       = 1'b0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= w;
        while (!taken)
        begin
            @(posedge clk);
            taken = !req_stall;
        end
        owed_rsp.push_back(supervise(w));
    endtask

    // Drop valid, wait for every owed word, then let the pipe go quiet.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [SILENCE_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        silence_lim = v;
    endtask

    // One round: the roster checks in (all of it, or a random pick that
    // leaves some clients silent), then a health check at a chosen distance
    // around the limit, then up to two first-timeout events.
    task automatic run_rounds(int n);
        logic [31:0] lim32;
        logic [31:0] step_max;
        logic [31:0] d;
        bit          whole;
        lim32    = {1'b0, silence_lim};
        step_max = lim32 / 64;
        for (int r = 0; r < n; r++)
        begin
            whole = $urandom_range(1);
            for (int k = 0; k < NUM_CLIENTS; k++)
            begin
                send_word(FUNC_CHECKIN,
                          whole ? roster_id[k] : roster_id[$urandom_range(NUM_CLIENTS - 1)],
                          tick);
                tick = tick + $urandom_range(step_max);
            end
            case ($urandom_range(3))
                0:       d = $urandom_range(lim32 / 2);
                1:       d = lim32 - 1 + $urandom_range(2);
                2:       d = lim32 + $urandom_range(lim32);
                default: d = $urandom;
            endcase
            tick = tick + d;
            send_word(FUNC_HEALTH, 16'($urandom), tick);
            repeat ($urandom_range(2))
                send_word(FUNC_TIMEOUT, 16'($urandom), $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Empty table passes; timeout clears only while healthy; id zero and
    // the unused func do nothing; ten clients fill the table, an eleventh is refused.
    task automatic test_registration();
        logic [15:0] ids [NUM_CLIENTS];
        ids = '{16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
                16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F, 16'hF0F0};
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_0000);
        send_word(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000);
        send_word(FUNC_TIMEOUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(FUNC_CHECKIN, 16'h0000, 32'hFFFF_FFFF);
        send_word(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        // check-in ticks straddle the 32-bit wrap
        for (int k = 0; k < NUM_CLIENTS; k++)
            send_word(FUNC_CHECKIN, ids[k], 32'hFFFF_FFF0 + 32'(4 * k));
        send_word(FUNC_CHECKIN, 16'h7777, 32'h0000_0030);
    endtask

    // Deadline edges: gap equal to the limit, a check-in in the future,
    // a zero limit, and the largest limit.
    task automatic test_staleness();
        send_word(FUNC_CHECKIN, 16'h5555, 32'h0000_0040);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_0050);
        send_word(FUNC_TIMEOUT, 16'h0000, 32'h0000_0050);
        // slot 0 is exactly at the reset limit of 300
        send_word(FUNC_HEALTH, 16'h0000, 32'hFFFF_FFF0 + 32'd300);
        send_word(FUNC_TIMEOUT, 16'h0000, 32'h0000_0120);
        send_word(FUNC_CHECKIN, 16'hFFFF, 32'h0000_1000);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_0200);
        write_limit('0);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_0800);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_1000);
        write_limit('1);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_0040 + 32'h7FFF_FFFF);
        send_word(FUNC_HEALTH, 16'h0000, 32'h0000_1000 + 32'h7FFF_FFFE);
        send_word(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000);
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------

    task automatic test_limit_sweep();
        write_limit(SILENCE_RESET);
        tick = $urandom;
        run_rounds(15);
        write_limit(31'd1);
        tick = $urandom;
        run_rounds(10);
        write_limit('1);
        tick = $urandom;
        run_rounds(10);
        write_limit(SILENCE_W'($urandom_range(2, 32'h7FFF_FFFE)));
        tick = $urandom;
        run_rounds(10);
    endtask

    // Garbage mix: any func, zero / known / unknown ids, ticks near or far.
    task automatic test_noise(int n);
        logic [15:0] id;
        logic [31:0] now;
        write_limit(SILENCE_W'($urandom_range(1, 5000)));
        tick = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:       id = 16'h0000;
                1:       id = roster_id[$urandom_range(NUM_CLIENTS - 1)];
                default: id = 16'($urandom);
            endcase
            now = $urandom_range(1) ? tick - $urandom_range(1000) : $urandom;
            tick = tick + $urandom_range(64);
            send_word(func_t'($urandom_range(int'(FUNC_UNUSED))), id, now);
        end
    endtask

    task automatic test_quiet_stretch();
        write_limit(SILENCE_W'($urandom_range(10, 5000)));
        calm = 1'b1;
        tick = $urandom;
        run_rounds(8);
        calm = 1'b0;
    endtask

    // Receiver holds off long enough that the block backs up into req_stall.
    task automatic test_backpressure();
        write_limit(SILENCE_W'($urandom_range(10, 5000)));
        hold_trig++;
        tick = $urandom;
        run_rounds(10);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CLIENTS; i++)
        begin
            roster_id[i]   = 16'd0;
            roster_tick[i] = 32'd0;
        end
        healthy_q   = 1'b0;
        silence_lim = SILENCE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_registration();
        test_staleness();
        test_limit_sweep();
        test_noise(120);
        test_quiet_stretch();
        test_backpressure();
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
